// ===== hdl/hybrid_merge_sorter_assert.svh =====
// Assertion helpers used by the sorter RTL.
`ifndef HYBRID_MERGE_SORTER_ASSERT_SVH
`define HYBRID_MERGE_SORTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define HMS_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("hms same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define HMS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("hms next-cycle check failed");

`endif

// ===== hdl/hms_pkg.sv =====
package hms_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    // one value slot moving between neighboring cells
    typedef struct packed {
        logic                     vld;
        logic signed [DATA_W-1:0] val;
    } t_link;

endpackage

// ===== hdl/hms_cell.sv =====
module hms_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,   // drain: take the right neighbor's value
    input  hms_pkg::t_link i_pass,    // value handed in from the left
    input  hms_pkg::t_link i_next,    // value held by the right neighbor
    output hms_pkg::t_link o_pass,    // value handed on to the right
    output hms_pkg::t_link o_held     // value held here
);

    logic                              r_full;
    logic signed [hms_pkg::DATA_W-1:0] r_val;
    logic                              r_pass_vld;
    logic signed [hms_pkg::DATA_W-1:0] r_pass_val;

    logic                              n_full;
    logic signed [hms_pkg::DATA_W-1:0] n_val;
    logic                              n_pass_vld;
    logic signed [hms_pkg::DATA_W-1:0] n_pass_val;
    logic                              w_less;

    assign w_less = i_pass.val < r_val;

    always_comb begin
        n_full     = r_full;
        n_val      = r_val;
        n_pass_vld = 1'b0;
        n_pass_val = r_pass_val;
        if (i_shift) begin
            n_full = i_next.vld;
            n_val  = i_next.val;
        end else if (i_pass.vld) begin
            if (!r_full) begin
                n_full = 1'b1;
                n_val  = i_pass.val;
            end else begin
                // keep the smaller, hand the larger on
                n_pass_vld = 1'b1;
                if (w_less) begin
                    n_val      = i_pass.val;
                    n_pass_val = r_val;
                end else begin
                    n_pass_val = i_pass.val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full     <= 1'b0;
            r_pass_vld <= 1'b0;
        end else begin
            r_full     <= n_full;
            r_pass_vld <= n_pass_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val      <= n_val;
        r_pass_val <= n_pass_val;
    end

    assign o_pass.vld = r_pass_vld;
    assign o_pass.val = r_pass_val;
    assign o_held.vld = r_full;
    assign o_held.val = r_val;

endmodule

// ===== hdl/hybrid_merge_sorter.sv =====
// Sorts a set of signed 32-bit values and streams it back in ascending order.
// Input stream (s_axis): tdata = value, tlast = last item of the set.
// Output stream (m_axis): tdata = sorted value, tlast = largest (final) value,
// tuser = some item of this set was dropped because the store was full.
// Values enter a row of MAX_ITEMS compare cells, one per cycle while tready is
// high; each cell keeps the smaller value and hands the larger one to its right
// neighbor. Up to MAX_ITEMS items per set are kept; later items are dropped and
// flagged. After the last item the row settles (worst-case travel of the final
// value through the row), then the smallest value sits in cell 0. tvalid rises
// when the settle wait ends; results then leave one per cycle while the receiver
// is ready, as the whole row shifts left. tready on the input stays low from the
// last item until the final result is taken.
// A stalled receiver simply holds the row: the current result stays on tdata.
// Synchronous active-low reset empties the row and returns to collecting.
module hybrid_merge_sorter #(
    parameter int MAX_ITEMS = hms_pkg::MAX_ITEMS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [hms_pkg::DATA_W-1:0] i_s_axis_tdata,  // [31:0] value
    input  logic                      i_s_axis_tlast,   // last_item
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [hms_pkg::DATA_W-1:0] o_m_axis_tdata,  // [31:0] sorted_value
    output logic                      o_m_axis_tlast,   // last_result
    output logic                      o_m_axis_tuser    // [0] dropped
);

    `include "hybrid_merge_sorter_assert.svh"

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    localparam logic [1:0] S_FILL   = 2'd0;
    localparam logic [1:0] S_SETTLE = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_wait,  n_wait;
    logic             r_ovf,   n_ovf;

    logic w_in_acc;
    logic w_out_acc;
    logic w_room;

    hms_pkg::t_link w_pass [0:MAX_ITEMS];
    hms_pkg::t_link w_held [0:MAX_ITEMS];
    logic [MAX_ITEMS-1:0] w_pass_vld;

    assign o_s_axis_tready = (r_state == S_FILL);
    assign o_m_axis_tvalid = (r_state == S_DRAIN);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc       = o_m_axis_tvalid && i_m_axis_tready;
    assign w_room          = r_count < CNT_W'(MAX_ITEMS);

    assign w_pass[0].vld     = w_in_acc && w_room;
    assign w_pass[0].val     = i_s_axis_tdata;
    assign w_held[MAX_ITEMS] = '0;

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        hms_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_out_acc),
            .i_pass  (w_pass[g]),
            .i_next  (w_held[g+1]),
            .o_pass  (w_pass[g+1]),
            .o_held  (w_held[g])
        );
        assign w_pass_vld[g] = w_pass[g+1].vld;
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_wait  = r_wait;
        n_ovf   = r_ovf;
        case (r_state)
            S_FILL: begin
                if (w_in_acc) begin
                    if (w_room) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_s_axis_tlast) begin
                        n_state = S_SETTLE;
                        n_wait  = '0;
                    end
                end
            end
            S_SETTLE: begin
                // let the last value ripple to its final cell
                n_wait = r_wait + CNT_W'(1);
                if (r_wait == CNT_W'(MAX_ITEMS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_out_acc) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_state = S_FILL;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_count <= '0;
            r_wait  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_wait  <= n_wait;
            r_ovf   <= n_ovf;
        end
    end

    assign o_m_axis_tdata = w_held[0].val;
    assign o_m_axis_tlast = (r_count == CNT_W'(1));
    assign o_m_axis_tuser = r_ovf;

    `HMS_ASSERT_NOW(a_drain_has_data, i_clk, i_rst_n,
        r_state == S_DRAIN, (r_count != '0) && w_held[0].vld && (w_pass_vld == '0))
    `HMS_ASSERT_NEXT(a_final_result_empties, i_clk, i_rst_n,
        w_out_acc && o_m_axis_tlast, (r_state == S_FILL) && (r_count == '0) && !r_ovf)
    `HMS_ASSERT_NEXT(a_drain_step, i_clk, i_rst_n,
        w_out_acc && !o_m_axis_tlast,
        (r_count == $past(r_count) - CNT_W'(1)) && $stable(r_ovf))
    `HMS_ASSERT_NEXT(a_full_drop_flags, i_clk, i_rst_n,
        w_in_acc && !w_room, r_ovf && (r_count == CNT_W'(MAX_ITEMS)))

endmodule
